// ===== rtl/csot_pkg.sv =====
// csot_pkg: shared types, widths and constants of the convex shape overlap test
// used by csot_geom, csot_cross and convex_shape_overlap_test_top
// no dependencies
package csot_pkg;

  // field and datapath widths; coordinates, sizes and offsets are in Q12.4 units
  localparam int CRD_W     = 16;              // centre coordinate
  localparam int SIZE_W    = 16;              // shape size
  localparam int H_W       = 15;              // half size and hexagon offsets
  localparam int T_W       = 25;              // half * 866 + 500
  localparam int RCP_W     = 26;              // reciprocal of 1000
  localparam int RCP_SHIFT = 35;
  localparam int OFS_W     = 16;              // signed vertex offset from centre
  localparam int D_W       = 17;              // signed centre difference
  localparam int PT_W      = 18;              // point relative to other centre
  localparam int NRM_W     = 17;              // edge normal component
  localparam int DF_W      = 19;              // point minus edge start
  localparam int PROD_W    = NRM_W + DF_W;    // one cross product term
  localparam int DOT_W     = PROD_W + 1;      // sum of both terms
  localparam int SHAPE_VTX = 6;               // most vertices any kind has
  localparam int CNT_W     = 3;               // vertex count

  // hexagon x offset: floor((half * 866 + 500) / 1000)
  localparam logic [T_W-1:0]   HEX_NUM  = 25'd866;
  localparam logic [T_W-1:0]   HEX_RND  = 25'd500;
  // ceil(2^35 / 1000), exact floor for every sum below 2^25
  localparam logic [RCP_W-1:0] RCP_1000 = 26'd34359739;

  // vertex counts of the kinds
  localparam logic [CNT_W-1:0] CNT_TRI = 3'd3;
  localparam logic [CNT_W-1:0] CNT_SQR = 3'd4;
  localparam logic [CNT_W-1:0] CNT_HEX = 3'd6;

  // shape kind, the unused code decodes as a hexagon
  typedef enum logic [1:0] {
    KIND_TRI = 2'd0,
    KIND_SQR = 2'd1,
    KIND_HEX = 2'd2
  } kind_t;

  // clockwise vertex offsets of one shape
  typedef struct packed {
    logic [SHAPE_VTX-1:0][OFS_W-1:0] x;
    logic [SHAPE_VTX-1:0][OFS_W-1:0] y;
    logic [CNT_W-1:0]                n;
  } vtx_set_t;

  // build the clockwise vertex list around the centre
  function automatic vtx_set_t build_vtx(kind_t k, logic [H_W-1:0] h,
                                         logic [H_W-1:0] hx, logic [H_W-1:0] hy);
    vtx_set_t        v;
    logic [OFS_W-1:0] ph, nh, phx, nhx, phy, nhy;
    ph  = {1'b0, h};
    nh  = OFS_W'(0) - ph;
    phx = {1'b0, hx};
    nhx = OFS_W'(0) - phx;
    phy = {1'b0, hy};
    nhy = OFS_W'(0) - phy;
    v   = '0;
    case (k)
      KIND_TRI: begin
        v.n    = CNT_TRI;
        v.x[0] = nh;  v.y[0] = ph;
        v.x[1] = ph;  v.y[1] = ph;
        v.x[2] = '0;  v.y[2] = nh;
      end
      KIND_SQR: begin
        v.n    = CNT_SQR;
        v.x[0] = ph;  v.y[0] = ph;
        v.x[1] = ph;  v.y[1] = nh;
        v.x[2] = nh;  v.y[2] = nh;
        v.x[3] = nh;  v.y[3] = ph;
      end
      default: begin
        v.n    = CNT_HEX;
        v.x[0] = '0;  v.y[0] = ph;
        v.x[1] = phx; v.y[1] = phy;
        v.x[2] = phx; v.y[2] = nhy;
        v.x[3] = '0;  v.y[3] = nh;
        v.x[4] = nhx; v.y[4] = nhy;
        v.x[5] = nhx; v.y[5] = phy;
      end
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/csot_geom.sv =====
// csot_geom: two pipeline stages that turn kind, size and centre of both shapes
// into vertex offsets, vertex counts and the centre difference
// depends on csot_pkg
module csot_geom #(
  parameter int NV = 6
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  output logic                                        in_ready,
  input  logic [1:0]                                  kind_a,
  input  logic [csot_pkg::SIZE_W-1:0]                 size_a,
  input  logic signed [csot_pkg::CRD_W-1:0]           a_x,
  input  logic signed [csot_pkg::CRD_W-1:0]           a_y,
  input  logic [1:0]                                  kind_b,
  input  logic [csot_pkg::SIZE_W-1:0]                 size_b,
  input  logic signed [csot_pkg::CRD_W-1:0]           b_x,
  input  logic signed [csot_pkg::CRD_W-1:0]           b_y,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output logic [1:0][NV-1:0][csot_pkg::OFS_W-1:0]     vtx_x,
  output logic [1:0][NV-1:0][csot_pkg::OFS_W-1:0]     vtx_y,
  output logic [1:0][csot_pkg::CNT_W-1:0]             cnt,
  output logic signed [csot_pkg::D_W-1:0]             d_x,
  output logic signed [csot_pkg::D_W-1:0]             d_y
);

  // stage 1: half size, hexagon numerator, centre difference
  logic                            g1_valid_r;
  csot_pkg::kind_t                 g1_kind_r [2];
  csot_pkg::kind_t                 g1_kind_nxt [2];
  logic [csot_pkg::H_W-1:0]        g1_h_r [2];
  logic [csot_pkg::H_W-1:0]        g1_h_nxt [2];
  logic [csot_pkg::T_W-1:0]        g1_t_r [2];
  logic [csot_pkg::T_W-1:0]        g1_t_nxt [2];
  logic signed [csot_pkg::D_W-1:0] g1_dx_r, g1_dx_nxt;
  logic signed [csot_pkg::D_W-1:0] g1_dy_r, g1_dy_nxt;

  // stage 2: vertex offsets
  logic                                      g2_valid_r;
  logic [1:0][NV-1:0][csot_pkg::OFS_W-1:0]   g2_x_r, g2_x_nxt;
  logic [1:0][NV-1:0][csot_pkg::OFS_W-1:0]   g2_y_r, g2_y_nxt;
  logic [1:0][csot_pkg::CNT_W-1:0]           g2_cnt_r, g2_cnt_nxt;
  logic signed [csot_pkg::D_W-1:0]           g2_dx_r, g2_dy_r;

  logic adv1, adv2;

  // stage advance, a bubble never blocks the stage behind it
  assign adv2     = !g2_valid_r || out_ready;
  assign adv1     = !g1_valid_r || adv2;
  assign in_ready = adv1;

  // stage 1 logic
  always_comb begin
    g1_kind_nxt[0] = csot_pkg::kind_t'(kind_a);
    g1_kind_nxt[1] = csot_pkg::kind_t'(kind_b);
    g1_h_nxt[0]    = size_a[csot_pkg::SIZE_W-1:1];
    g1_h_nxt[1]    = size_b[csot_pkg::SIZE_W-1:1];
    for (int s = 0; s < 2; s++) begin
      g1_t_nxt[s] = csot_pkg::T_W'(g1_h_nxt[s]) * csot_pkg::HEX_NUM + csot_pkg::HEX_RND;
    end
    g1_dx_nxt = csot_pkg::D_W'(a_x) - csot_pkg::D_W'(b_x);
    g1_dy_nxt = csot_pkg::D_W'(a_y) - csot_pkg::D_W'(b_y);
  end

  // stage 2 logic: divide by 1000 through the reciprocal, then place vertices
  always_comb begin
    logic [csot_pkg::T_W+csot_pkg::RCP_W-1:0] q_full;
    logic [csot_pkg::H_W-1:0]                 hx, hy;
    csot_pkg::vtx_set_t                       vs;
    g2_x_nxt   = '0;
    g2_y_nxt   = '0;
    g2_cnt_nxt = '0;
    for (int s = 0; s < 2; s++) begin
      q_full = {{csot_pkg::RCP_W{1'b0}}, g1_t_r[s]} *
               {{csot_pkg::T_W{1'b0}}, csot_pkg::RCP_1000};
      hx = q_full[csot_pkg::RCP_SHIFT +: csot_pkg::H_W];
      hy = g1_h_r[s] >> 1;
      vs = csot_pkg::build_vtx(g1_kind_r[s], g1_h_r[s], hx, hy);
      for (int i = 0; i < NV; i++) begin
        g2_x_nxt[s][i] = vs.x[i];
        g2_y_nxt[s][i] = vs.y[i];
      end
      // kinds with more vertices than lanes keep the first ones
      g2_cnt_nxt[s] = (vs.n > csot_pkg::CNT_W'(NV)) ? csot_pkg::CNT_W'(NV) : vs.n;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_valid_r <= 1'b0;
      g2_valid_r <= 1'b0;
    end else begin
      if (adv1) g1_valid_r <= in_valid;
      if (adv2) g2_valid_r <= g1_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv1) begin
      g1_kind_r <= g1_kind_nxt;
      g1_h_r    <= g1_h_nxt;
      g1_t_r    <= g1_t_nxt;
      g1_dx_r   <= g1_dx_nxt;
      g1_dy_r   <= g1_dy_nxt;
    end
    if (adv2) begin
      g2_x_r   <= g2_x_nxt;
      g2_y_r   <= g2_y_nxt;
      g2_cnt_r <= g2_cnt_nxt;
      g2_dx_r  <= g1_dx_r;
      g2_dy_r  <= g1_dy_r;
    end
  end

  assign out_valid = g2_valid_r;
  assign vtx_x     = g2_x_r;
  assign vtx_y     = g2_y_r;
  assign cnt       = g2_cnt_r;
  assign d_x       = g2_dx_r;
  assign d_y       = g2_dy_r;

endmodule

// ===== rtl/csot_cross.sv =====
// csot_cross: two pipeline stages of edge tests, every vertex of each shape
// against every edge of the other, giving one sign bit per pair
// depends on csot_pkg
module csot_cross #(
  parameter int NV = 6
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [1:0][NV-1:0][csot_pkg::OFS_W-1:0]  vtx_x,
  input  logic [1:0][NV-1:0][csot_pkg::OFS_W-1:0]  vtx_y,
  input  logic [1:0][csot_pkg::CNT_W-1:0]          cnt,
  input  logic signed [csot_pkg::D_W-1:0]          d_x,
  input  logic signed [csot_pkg::D_W-1:0]          d_y,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [1:0][NV-1:0][NV-1:0]               neg,
  output logic [1:0][csot_pkg::CNT_W-1:0]          cnt_out
);

  // stage 1: points relative to the other centre, edge starts and normals
  // direction 0 tests A's vertices on B's edges, direction 1 the reverse
  logic                               c1_valid_r;
  logic signed [csot_pkg::PT_W-1:0]   c1_pt_x_r  [2][NV];
  logic signed [csot_pkg::PT_W-1:0]   c1_pt_x_nxt [2][NV];
  logic signed [csot_pkg::PT_W-1:0]   c1_pt_y_r  [2][NV];
  logic signed [csot_pkg::PT_W-1:0]   c1_pt_y_nxt [2][NV];
  logic signed [csot_pkg::OFS_W-1:0]  c1_st_x_r  [2][NV];
  logic signed [csot_pkg::OFS_W-1:0]  c1_st_x_nxt [2][NV];
  logic signed [csot_pkg::OFS_W-1:0]  c1_st_y_r  [2][NV];
  logic signed [csot_pkg::OFS_W-1:0]  c1_st_y_nxt [2][NV];
  logic signed [csot_pkg::NRM_W-1:0]  c1_nx_r    [2][NV];
  logic signed [csot_pkg::NRM_W-1:0]  c1_nx_nxt  [2][NV];
  logic signed [csot_pkg::NRM_W-1:0]  c1_ny_r    [2][NV];
  logic signed [csot_pkg::NRM_W-1:0]  c1_ny_nxt  [2][NV];
  logic [1:0][csot_pkg::CNT_W-1:0]    c1_cnt_r;

  // stage 2: sign of each cross product
  logic                               c2_valid_r;
  logic [1:0][NV-1:0][NV-1:0]         c2_neg_r, c2_neg_nxt;
  logic [1:0][csot_pkg::CNT_W-1:0]    c2_cnt_r;

  logic adv1, adv2;

  assign adv2     = !c2_valid_r || out_ready;
  assign adv1     = !c1_valid_r || adv2;
  assign in_ready = adv1;

  // stage 1 logic
  always_comb begin
    int                         q;
    int                         jn;
    logic [csot_pkg::OFS_W-1:0] ex, ey;
    for (int r = 0; r < 2; r++) begin
      q = 1 - r;
      for (int i = 0; i < NV; i++) begin
        if (r == 0) begin
          c1_pt_x_nxt[r][i] = csot_pkg::PT_W'($signed(vtx_x[0][i])) + csot_pkg::PT_W'(d_x);
          c1_pt_y_nxt[r][i] = csot_pkg::PT_W'($signed(vtx_y[0][i])) + csot_pkg::PT_W'(d_y);
        end else begin
          c1_pt_x_nxt[r][i] = csot_pkg::PT_W'($signed(vtx_x[1][i])) - csot_pkg::PT_W'(d_x);
          c1_pt_y_nxt[r][i] = csot_pkg::PT_W'($signed(vtx_y[1][i])) - csot_pkg::PT_W'(d_y);
        end
      end
      for (int j = 0; j < NV; j++) begin
        jn = (j == NV - 1) ? 0 : j + 1;
        // closing edge runs back to the first vertex
        if (csot_pkg::CNT_W'(j + 1) == cnt[q]) begin
          ex = vtx_x[q][0];
          ey = vtx_y[q][0];
        end else begin
          ex = vtx_x[q][jn];
          ey = vtx_y[q][jn];
        end
        c1_st_x_nxt[r][j] = $signed(vtx_x[q][j]);
        c1_st_y_nxt[r][j] = $signed(vtx_y[q][j]);
        c1_nx_nxt[r][j]   = csot_pkg::NRM_W'($signed(vtx_y[q][j])) -
                            csot_pkg::NRM_W'($signed(ey));
        c1_ny_nxt[r][j]   = csot_pkg::NRM_W'($signed(ex)) -
                            csot_pkg::NRM_W'($signed(vtx_x[q][j]));
      end
    end
  end

  // stage 2 logic: nx * (px - sx) + ny * (py - sy) below zero
  always_comb begin
    logic signed [csot_pkg::DF_W-1:0]   dfx, dfy;
    logic signed [csot_pkg::PROD_W-1:0] px, py;
    logic signed [csot_pkg::DOT_W-1:0]  dot;
    c2_neg_nxt = '0;
    for (int r = 0; r < 2; r++) begin
      for (int i = 0; i < NV; i++) begin
        for (int j = 0; j < NV; j++) begin
          dfx = csot_pkg::DF_W'(c1_pt_x_r[r][i]) - csot_pkg::DF_W'(c1_st_x_r[r][j]);
          dfy = csot_pkg::DF_W'(c1_pt_y_r[r][i]) - csot_pkg::DF_W'(c1_st_y_r[r][j]);
          px  = csot_pkg::PROD_W'(c1_nx_r[r][j]) * csot_pkg::PROD_W'(dfx);
          py  = csot_pkg::PROD_W'(c1_ny_r[r][j]) * csot_pkg::PROD_W'(dfy);
          dot = csot_pkg::DOT_W'(px) + csot_pkg::DOT_W'(py);
          c2_neg_nxt[r][i][j] = dot[csot_pkg::DOT_W-1];
        end
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_valid_r <= 1'b0;
      c2_valid_r <= 1'b0;
    end else begin
      if (adv1) c1_valid_r <= in_valid;
      if (adv2) c2_valid_r <= c1_valid_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (adv1) begin
      c1_pt_x_r <= c1_pt_x_nxt;
      c1_pt_y_r <= c1_pt_y_nxt;
      c1_st_x_r <= c1_st_x_nxt;
      c1_st_y_r <= c1_st_y_nxt;
      c1_nx_r   <= c1_nx_nxt;
      c1_ny_r   <= c1_ny_nxt;
      c1_cnt_r  <= cnt;
    end
    if (adv2) begin
      c2_neg_r <= c2_neg_nxt;
      c2_cnt_r <= c1_cnt_r;
    end
  end

  assign out_valid = c2_valid_r;
  assign neg       = c2_neg_r;
  assign cnt_out   = c2_cnt_r;

endmodule

// ===== rtl/convex_shape_overlap_test_top.sv =====
// Convex shape overlap test. Each request carries two shapes (triangle, square or
// hexagon, size in unsigned Q12.4, centre in signed Q12.4) and gives one result:
// overlap is 1 when a vertex of either shape lies strictly inside the other, a
// vertex on an edge does not count. A new request is taken every cycle while the
// output is not stalled; a result passes through five register stages: half size
// and hexagon numerator, vertex build with the divide by 1000, points and edge
// normals, all MAX_VERTICES x MAX_VERTICES edge tests per direction in parallel
// (two multipliers each), and the final reduction in the output register. A stall
// holds every stage; empty stages still fill while the output waits.
// depends on csot_pkg, csot_geom, csot_cross
module convex_shape_overlap_test_top #(
  parameter int MAX_VERTICES = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_kind_a,
  input  logic [csot_pkg::SIZE_W-1:0]       in_size_a,
  input  logic signed [csot_pkg::CRD_W-1:0] in_a_x,
  input  logic signed [csot_pkg::CRD_W-1:0] in_a_y,
  input  logic [1:0]                        in_kind_b,
  input  logic [csot_pkg::SIZE_W-1:0]       in_size_b,
  input  logic signed [csot_pkg::CRD_W-1:0] in_b_x,
  input  logic signed [csot_pkg::CRD_W-1:0] in_b_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_overlap
);

  localparam int NV = MAX_VERTICES;

  logic                                      g_valid, g_ready;
  logic [1:0][NV-1:0][csot_pkg::OFS_W-1:0]   g_vtx_x, g_vtx_y;
  logic [1:0][csot_pkg::CNT_W-1:0]           g_cnt;
  logic signed [csot_pkg::D_W-1:0]           g_dx, g_dy;

  logic                                      x_valid, x_ready;
  logic [1:0][NV-1:0][NV-1:0]                x_neg;
  logic [1:0][csot_pkg::CNT_W-1:0]           x_cnt;

  logic out_valid_r;
  logic out_overlap_r, out_overlap_nxt;
  logic out_adv;

  // shape geometry
  csot_geom #(.NV(NV)) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind_a    (in_kind_a),
    .size_a    (in_size_a),
    .a_x       (in_a_x),
    .a_y       (in_a_y),
    .kind_b    (in_kind_b),
    .size_b    (in_size_b),
    .b_x       (in_b_x),
    .b_y       (in_b_y),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .vtx_x     (g_vtx_x),
    .vtx_y     (g_vtx_y),
    .cnt       (g_cnt),
    .d_x       (g_dx),
    .d_y       (g_dy)
  );

  // edge tests
  csot_cross #(.NV(NV)) u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .vtx_x     (g_vtx_x),
    .vtx_y     (g_vtx_y),
    .cnt       (g_cnt),
    .d_x       (g_dx),
    .d_y       (g_dy),
    .out_valid (x_valid),
    .out_ready (x_ready),
    .neg       (x_neg),
    .cnt_out   (x_cnt)
  );

  assign out_adv = !out_valid_r || out_ready;
  assign x_ready = out_adv;

  // a point is inside when it is behind every kept edge; any inside vertex hits
  always_comb begin
    logic pt_in;
    out_overlap_nxt = 1'b0;
    for (int r = 0; r < 2; r++) begin
      for (int i = 0; i < NV; i++) begin
        pt_in = 1'b1;
        for (int j = 0; j < NV; j++) begin
          if ((csot_pkg::CNT_W'(j) < x_cnt[1-r]) && !x_neg[r][i][j]) pt_in = 1'b0;
        end
        if ((csot_pkg::CNT_W'(i) < x_cnt[r]) && pt_in) out_overlap_nxt = 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= x_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_overlap_r <= out_overlap_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_overlap = out_overlap_r;

`ifndef SYNTHESIS
  // input blocked only when the output holds a result that is not taken
  ast_block_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready))
    else $error("input blocked without an output stall");

  // a finished test moving on lands in the output register
  ast_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (x_valid && out_adv) |=> out_valid_r)
    else $error("edge test result lost at output stage");

  // a held output stage holds the test stage behind it
  ast_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    (x_valid && !out_adv) |-> !x_ready)
    else $error("test stage released while output stalled");
`endif

endmodule

// ===== tb/csot_overlap_checker.sv =====
`timescale 1ns / 100ps
// csot_overlap_checker: watches the request and result channels of the convex shape
// overlap test, predicts the overlap bit of every accepted request and compares
// depends on csot_pkg
module csot_overlap_checker #(
  parameter int MAX_VERTICES = 6
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [1:0]                        in_kind_a,
  input  logic [csot_pkg::SIZE_W-1:0]       in_size_a,
  input  logic signed [csot_pkg::CRD_W-1:0] in_a_x,
  input  logic signed [csot_pkg::CRD_W-1:0] in_a_y,
  input  logic [1:0]                        in_kind_b,
  input  logic [csot_pkg::SIZE_W-1:0]       in_size_b,
  input  logic signed [csot_pkg::CRD_W-1:0] in_b_x,
  input  logic signed [csot_pkg::CRD_W-1:0] in_b_y,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic                              out_overlap,
  output int                                n_pending,
  output int                                n_checked,
  output int                                n_hits,
  output int                                n_errors
);

  // hexagon x offset is half * 0.866, rounded to nearest with ties up
  localparam longint HEX_MUL = 866;
  localparam longint HEX_RND = 500;
  localparam longint HEX_DIV = 1000;
  localparam int     SHOW_MAX = 10;

  // clockwise corners of one shape, relative to its centre
  typedef struct {
    longint x[csot_pkg::SHAPE_VTX];
    longint y[csot_pkg::SHAPE_VTX];
    int     n;
  } outline_t;

  bit overlap_q[$];
  int checked_cnt;
  int hit_cnt;
  int err_cnt;

  function automatic outline_t make_outline(logic [1:0] kind,
                                            logic [csot_pkg::SIZE_W-1:0] size);
    outline_t o;
    longint   h, hx, hy;
    int       i;
    h  = longint'(size >> 1);
    hx = (h * HEX_MUL + HEX_RND) / HEX_DIV;
    hy = h >>> 1;
    for (i = 0; i < csot_pkg::SHAPE_VTX; i++) begin
      o.x[i] = 0;
      o.y[i] = 0;
    end
    case (csot_pkg::kind_t'(kind))
      csot_pkg::KIND_TRI: begin
        o.n = 3;
        o.x[0] = -h; o.y[0] = h;
        o.x[1] = h;  o.y[1] = h;
        o.x[2] = 0;  o.y[2] = -h;
      end
      csot_pkg::KIND_SQR: begin
        o.n = 4;
        o.x[0] = h;  o.y[0] = h;
        o.x[1] = h;  o.y[1] = -h;
        o.x[2] = -h; o.y[2] = -h;
        o.x[3] = -h; o.y[3] = h;
      end
      // hexagon, and the spare code since only bit 1 picks the hexagon
      default: begin
        o.n = 6;
        o.x[0] = 0;   o.y[0] = h;
        o.x[1] = hx;  o.y[1] = hy;
        o.x[2] = hx;  o.y[2] = -hy;
        o.x[3] = 0;   o.y[3] = -h;
        o.x[4] = -hx; o.y[4] = -hy;
        o.x[5] = -hx; o.y[5] = hy;
      end
    endcase
    // excess corners are dropped, the closing edge returns to the first
    if (o.n > MAX_VERTICES) o.n = MAX_VERTICES;
    return o;
  endfunction

  // strictly behind every edge, a point on an edge is outside
  function automatic bit strictly_inside(outline_t o, longint px, longint py);
    int     i, j;
    longint nx, ny, d;
    for (i = 0; i < o.n; i++) begin
      j  = (i + 1 == o.n) ? 0 : i + 1;
      nx = -(o.y[j] - o.y[i]);
      ny = o.x[j] - o.x[i];
      d  = nx * (px - o.x[i]) + ny * (py - o.y[i]);
      if (d >= 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // any corner of p, placed at (px,py), inside q placed at (qx,qy)
  function automatic bit corner_inside(outline_t p, longint px, longint py,
                                       outline_t q, longint qx, longint qy);
    int i;
    for (i = 0; i < p.n; i++)
      if (strictly_inside(q, p.x[i] + px - qx, p.y[i] + py - qy)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit shapes_overlap();
    outline_t sa, sb;
    longint   ax, ay, bx, by;
    sa = make_outline(in_kind_a, in_size_a);
    sb = make_outline(in_kind_b, in_size_b);
    ax = longint'(in_a_x);
    ay = longint'(in_a_y);
    bx = longint'(in_b_x);
    by = longint'(in_b_y);
    return corner_inside(sa, ax, ay, sb, bx, by) || corner_inside(sb, bx, by, sa, ax, ay);
  endfunction

  // predict on request, compare on result
  always @(posedge clk) begin : watch
    bit want;
    if (!rst_n) begin
      overlap_q.delete();
    end else begin
      if (in_valid && in_ready) overlap_q.push_back(shapes_overlap());
      if (out_valid && out_ready) begin
        if (overlap_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= SHOW_MAX)
            $display("%0t: result with no request waiting, overlap %0b", $realtime,
                     out_overlap);
        end else begin
          want = overlap_q.pop_front();
          checked_cnt++;
          if (out_overlap === 1'b1) hit_cnt++;
          if (out_overlap !== want) begin
            err_cnt++;
            if (err_cnt <= SHOW_MAX)
              $display("%0t: result %0d overlap expected %0b, got %0b", $realtime,
                       checked_cnt, want, out_overlap);
          end
        end
      end
    end
    n_pending <= overlap_q.size();
    n_checked <= checked_cnt;
    n_hits    <= hit_cnt;
    n_errors  <= err_cnt;
  end

endmodule

// ===== tb/convex_shape_overlap_test_top_test.sv =====
`timescale 1ns / 100ps
// convex_shape_overlap_test_top_test: drives shape pair requests into the overlap
// test and gives the verdict; checking is done in csot_overlap_checker
// depends on csot_pkg, csot_overlap_checker and convex_shape_overlap_test_top
module convex_shape_overlap_test_top_test;

  localparam int         VTX_LIMIT   = 6;
  localparam logic [1:0] KIND_SPARE  = 2'd3;   // code with no meaning, acts as hexagon
  localparam int         N_RANDOM    = 480;
  localparam int         N_CLOSING   = 80;     // last random requests, no idling
  localparam int         HOLD_AT     = 200;
  localparam int         HOLD_CYCLES = 60;
  localparam int         PAUSE_AT    = 300;
  localparam int         QUIET_LIMIT = 1000;
  localparam int         DRAIN_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]                        kind_a;
    logic [csot_pkg::SIZE_W-1:0]       size_a;
    logic signed [csot_pkg::CRD_W-1:0] a_x;
    logic signed [csot_pkg::CRD_W-1:0] a_y;
    logic [1:0]                        kind_b;
    logic [csot_pkg::SIZE_W-1:0]       size_b;
    logic signed [csot_pkg::CRD_W-1:0] b_x;
    logic signed [csot_pkg::CRD_W-1:0] b_y;
  } pair_t;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic [1:0]                        in_kind_a;
  logic [csot_pkg::SIZE_W-1:0]       in_size_a;
  logic signed [csot_pkg::CRD_W-1:0] in_a_x;
  logic signed [csot_pkg::CRD_W-1:0] in_a_y;
  logic [1:0]                        in_kind_b;
  logic [csot_pkg::SIZE_W-1:0]       in_size_b;
  logic signed [csot_pkg::CRD_W-1:0] in_b_x;
  logic signed [csot_pkg::CRD_W-1:0] in_b_y;
  logic                              out_valid;
  logic                              out_ready;
  logic                              out_overlap;

  int n_pending, n_checked, n_hits, n_errors;
  int n_sent;
  int quiet_cycles;
  bit closing_run;

  convex_shape_overlap_test_top #(.MAX_VERTICES(VTX_LIMIT)) dut (.*);

  csot_overlap_checker #(.MAX_VERTICES(VTX_LIMIT)) u_checker (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, one long hold-off, always ready at the end
  initial begin : rx
    bit held;
    held      = 1'b0;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (closing_run) begin
        out_ready <= 1'b1;
      end else if (!held && n_sent >= HOLD_AT) begin
        // long hold-off so the pipe fills and backs up into the request side
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  function automatic pair_t shape_pair(logic [1:0] ka, int sa, int ax, int ay,
                                       logic [1:0] kb, int sb, int bx, int by);
    pair_t p;
    p.kind_a = ka;
    p.size_a = csot_pkg::SIZE_W'(sa);
    p.a_x    = csot_pkg::CRD_W'(ax);
    p.a_y    = csot_pkg::CRD_W'(ay);
    p.kind_b = kb;
    p.size_b = csot_pkg::SIZE_W'(sb);
    p.b_x    = csot_pkg::CRD_W'(bx);
    p.b_y    = csot_pkg::CRD_W'(by);
    return p;
  endfunction

  // mostly neighboring shapes, some grid aligned contact cases, some raw noise
  function automatic pair_t random_pair();
    int pick, sa, sb, ax, ay, dx, dy, span;
    pick = $urandom_range(0, 19);
    if (pick < 5) begin
      return shape_pair(2'($urandom_range(0, 3)), int'($urandom_range(0, 65535)),
                        int'($urandom), int'($urandom),
                        2'($urandom_range(0, 3)), int'($urandom_range(0, 65535)),
                        int'($urandom), int'($urandom));
    end
    if (pick < 8) begin
      // corners land on edges often here
      sa = 32 * int'($urandom_range(0, 16));
      sb = 32 * int'($urandom_range(0, 16));
      ax = 16 * int'($urandom_range(0, 64)) - 512;
      ay = 16 * int'($urandom_range(0, 64)) - 512;
      dx = 16 * (int'($urandom_range(0, 32)) - 16);
      dy = 16 * (int'($urandom_range(0, 32)) - 16);
    end else begin
      sa = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 65535))
                                       : int'($urandom_range(0, 2047));
      sb = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 65535))
                                       : int'($urandom_range(0, 2047));
      ax   = int'($urandom_range(0, 65535)) - 32768;
      ay   = int'($urandom_range(0, 65535)) - 32768;
      span = (sa + sb) / 2 + 8;
      dx   = int'($urandom_range(0, 2 * span)) - span;
      dy   = int'($urandom_range(0, 2 * span)) - span;
    end
    return shape_pair(2'($urandom_range(0, 2)), sa, ax, ay,
                      2'($urandom_range(0, 2)), sb, ax + dx, ay + dy);
  endfunction

  // hold the request until accepted
  task automatic offer(input pair_t p);
    in_valid  <= 1'b1;
    in_kind_a <= p.kind_a;
    in_size_a <= p.size_a;
    in_a_x    <= p.a_x;
    in_a_y    <= p.a_y;
    in_kind_b <= p.kind_b;
    in_size_b <= p.size_b;
    in_b_x    <= p.b_x;
    in_b_y    <= p.b_y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic maybe_idle();
    if (!closing_run && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // stop offering until every outstanding request has its result
  task automatic wait_for_results();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // reset, directed requests, random requests, verdict
  initial begin
    int ka, kb, i;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_kind_a   = '0;
    in_size_a   = '0;
    in_a_x      = '0;
    in_a_y      = '0;
    in_kind_b   = '0;
    in_size_b   = '0;
    in_b_x      = '0;
    in_b_y      = '0;
    n_sent      = 0;
    closing_run = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // degenerate and boundary pairs
    offer(shape_pair(csot_pkg::KIND_SQR, 0, 0, 0, csot_pkg::KIND_SQR, 0, 0, 0));
    maybe_idle();
    offer(shape_pair(csot_pkg::KIND_TRI, 0, 0, 0, csot_pkg::KIND_SQR, 64, 0, 0));
    maybe_idle();
    offer(shape_pair(csot_pkg::KIND_SQR, 32, 0, 0, csot_pkg::KIND_SQR, 32, 32, 0));
    maybe_idle();
    offer(shape_pair(csot_pkg::KIND_SQR, 32, 0, 0, csot_pkg::KIND_SQR, 32, 31, 0));
    maybe_idle();
    offer(shape_pair(csot_pkg::KIND_SQR, 65535, -32768, -32768,
                     csot_pkg::KIND_SQR, 65535, 32767, 32767));
    maybe_idle();
    offer(shape_pair(csot_pkg::KIND_HEX, 65535, 32767, 32767,
                     csot_pkg::KIND_TRI, 65535, 32767, 32767));
    maybe_idle();
    offer(shape_pair(KIND_SPARE, 64, 0, 0, csot_pkg::KIND_TRI, 16, 0, 0));
    maybe_idle();
    offer(shape_pair(csot_pkg::KIND_HEX, 1, -32768, 32767,
                     csot_pkg::KIND_HEX, 65534, -32768, 32767));
    maybe_idle();
    offer(shape_pair(csot_pkg::KIND_TRI, 65535, -32768, 32767,
                     csot_pkg::KIND_SQR, 65535, 32767, -32768));
    maybe_idle();

    // every kind against every kind, spare code included
    for (ka = 0; ka < 4; ka++) begin
      for (kb = 0; kb < 4; kb++) begin
        offer(shape_pair(2'(ka), 96 + 16 * ka, 0, 16 * kb,
                         2'(kb), 80 + 16 * kb, 24, -8 * ka));
        maybe_idle();
      end
    end
    wait_for_results();

    // random requests
    for (i = 0; i < N_RANDOM; i++) begin
      if (i >= N_RANDOM - N_CLOSING) closing_run = 1'b1;
      offer(random_pair());
      if (n_sent == PAUSE_AT) wait_for_results();
      else maybe_idle();
    end

    wait_for_results();
    repeat (10) @(posedge clk);

    $display("sent %0d requests: every kind pair incl. the spare code, zero and full sizes,",
             n_sent);
    $display("edge contact and wrapped centres; %0d results checked, %0d with overlap",
             n_checked, n_hits);
    if (n_errors == 0 && n_pending == 0) begin
      $display("No mismatches found");
    end else begin
      if (n_pending != 0) $display("%0d requests never got a result", n_pending);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/csot_pkg.sv
rtl/csot_geom.sv
rtl/csot_cross.sv
rtl/convex_shape_overlap_test_top.sv
tb/csot_overlap_checker.sv
tb/convex_shape_overlap_test_top_test.sv
